// ===== src/tlvp_pkg.sv =====
// Shared types and constants of the TLV request packet parser.
package tlvp_pkg;

	localparam int HEADER_BYTES      = 8;
	localparam int ATTR_HEADER_BYTES = 4;

	// Byte offsets of the header fields and the attribute header window.
	localparam int HDR_TYPE_OFF   = 4;
	localparam int HDR_LEN_OFF    = 6;
	localparam int HDR_END_OFF    = 8;
	localparam int ATTR_SHIFT_LEN = 4;

	localparam int POS_W   = 17;
	localparam int TDATA_W = 128;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_ATTR   = 2'd1,
		PH_DATA   = 2'd2,
		PH_TRAIL  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_ATTR   = 2'd1,
		KIND_DATA   = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] req_number;
		logic [15:0] req_kind;
		logic [15:0] packet_length;
		logic [15:0] attr_code;
		logic [15:0] attr_data_length;
		logic [15:0] attr_start;
		logic [7:0]  data_byte;
		logic        ok;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    v0;
		result_t r0;
		logic    v1;
		result_t r1;
	} res_pair_t;

	typedef struct packed {
		logic              room;
		logic [QCNT_W-1:0] level;
	} q_status_t;

endpackage

// ===== src/tlv_request_packet_parser.sv =====
// Top level of the TLV request packet parser: input register, parser and result queue.
//
// The block takes a request packet one byte per transfer on the slave stream, with
// tlast on the final byte of the buffer. It reports the 8-byte big-endian header
// (request number, request type, packet length), then each attribute header with its
// code, data length and start offset, then every data byte, and finally an end verdict
// with tlast set and ok telling whether the packet was well formed; check_enable at 0
// keeps ok at 1. One byte is accepted in every clock cycle while the result queue has
// room. Each byte gives at most one result, except the final byte of a buffer, which
// may give its own result and the verdict; the four-entry result queue absorbs that
// second result. A byte passes through the input register and the result queue on its
// way to the master stream. Results are packed into tdata with unused fields zero;
// tuser carries the result kind. After the verdict the parse state returns to its
// reset value, ready for the next buffer.
module tlv_request_packet_parser
	import tlvp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration: check_enable register.
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	// Slave stream.
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // byte_in [7:0]
	input  logic               s_axis_tlast,
	// Master stream.
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// req_number [31:0], req_kind [47:32], packet_length [63:48], attr_code [79:64],
	// attr_data_length [95:80], attr_start [111:96], data_byte [119:112], ok [120],
	// zero fill [127:121]
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]         m_axis_tuser,  // kind [1:0]
	output logic               m_axis_tlast
);

	logic        check_enable_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eob_s1;
	logic        advance;
	logic        in_fire;
	res_pair_t   res;
	result_t     head;
	q_status_t   qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			check_enable_q <= cfg_wr_data;
		end
	end

	// The registered byte moves into the parser whenever the queue has room for the
	// two results it may give; an empty input register takes a new byte even when it has not.
	assign advance       = valid_s1 & qstat.room;
	assign s_axis_tready = ~valid_s1 | qstat.room;
	assign in_fire       = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_axis_tdata;
			eob_s1  <= s_axis_tlast;
		end
	end

	tlvp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.byte_val     (byte_s1),
		.eob          (eob_s1),
		.check_enable (check_enable_q),
		.res          (res)
	);

	tlvp_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res),
		.head       (head),
		.head_valid (m_axis_tvalid),
		.head_ready (m_axis_tready),
		.status     (qstat)
	);

	assign m_axis_tdata = {7'b0, head.ok, head.data_byte, head.attr_start,
		head.attr_data_length, head.attr_code, head.packet_length, head.req_kind,
		head.req_number};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

	// The queue never holds more entries than it has.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= QCNT_W'(QDEPTH))
		else $error("result queue overfilled");

	// A stalled input register keeps its byte until the parser takes it.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !qstat.room) |=> (valid_s1 && $stable(byte_s1) && $stable(eob_s1)))
		else $error("input register lost a stalled byte");

	// Only the verdict closes a buffer.
	a_last_is_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_END))
		else $error("tlast on a result other than the verdict");

	// Output valid follows the queue fill level.
	a_valid_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid == (qstat.level != '0))
		else $error("output valid disagrees with queue level");

endmodule

// ===== src/tlvp_parse.sv =====
// Per-byte parse state and the logic that turns one byte into its results.
module tlvp_parse
	import tlvp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_val,
	input  logic        eob,
	input  logic        check_enable,
	output res_pair_t   res
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [31:0]      num_q, num_d;
	logic [15:0]      type_q, type_d;
	logic [15:0]      len_q, len_d;
	logic [31:0]      shift_q, shift_d;
	logic [15:0]      begin_q, begin_d;
	logic [POS_W-1:0] aend_q, aend_d;
	phase_t           phase_q, phase_d;
	logic             err_q, err_d;

	logic             emit;
	result_t          r0;
	result_t          r1;
	logic             sn_go;
	logic [POS_W-1:0] sn_pos;
	logic [POS_W-1:0] off;
	logic [15:0]      alen;
	logic [POS_W-1:0] aend_new;
	logic             err_v;

	always_comb begin
		num_d   = num_q;
		type_d  = type_q;
		len_d   = len_q;
		shift_d = shift_q;
		begin_d = begin_q;
		aend_d  = aend_q;
		phase_d = phase_q;
		err_d   = err_q;
		emit    = 1'b0;
		r0      = '0;
		sn_go   = 1'b0;
		sn_pos  = '0;
		off     = pos_q - {1'b0, begin_q};
		alen    = '0;
		aend_new = '0;

		case (phase_q)
			PH_HEADER: begin
				if (pos_q < POS_W'(HDR_TYPE_OFF)) begin
					num_d = {num_q[23:0], byte_val};
				end else if (pos_q < POS_W'(HDR_LEN_OFF)) begin
					type_d = {type_q[7:0], byte_val};
				end else if (pos_q < POS_W'(HDR_END_OFF)) begin
					len_d = {len_q[7:0], byte_val};
				end
				if (pos_q == POS_W'(HEADER_BYTES - 1)) begin
					emit             = 1'b1;
					r0.kind          = KIND_HEADER;
					r0.req_number    = num_d;
					r0.req_kind      = type_d;
					r0.packet_length = len_d;
					sn_go            = 1'b1;
					sn_pos           = POS_W'(HEADER_BYTES);
				end
			end
			PH_ATTR: begin
				if (off < POS_W'(ATTR_SHIFT_LEN)) begin
					shift_d = {shift_q[23:0], byte_val};
				end
				if (off == POS_W'(ATTR_HEADER_BYTES - 1)) begin
					alen     = shift_d[15:0];
					aend_new = {1'b0, begin_q} + {1'b0, alen};
					if (alen < 16'(ATTR_HEADER_BYTES) || aend_new[POS_W-1]) begin
						err_d   = 1'b1;
						phase_d = PH_TRAIL;
					end else begin
						aend_d = aend_new;
						if (aend_new > {1'b0, len_q}) begin
							err_d = 1'b1;
						end
						emit                = 1'b1;
						r0.kind             = KIND_ATTR;
						r0.attr_code        = shift_d[31:16];
						r0.attr_data_length = alen - 16'(ATTR_HEADER_BYTES);
						r0.attr_start       = begin_q;
						if (alen == 16'(ATTR_HEADER_BYTES)) begin
							sn_go  = 1'b1;
							sn_pos = aend_new;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
			end
			PH_DATA: begin
				emit         = 1'b1;
				r0.kind      = KIND_DATA;
				r0.data_byte = byte_val;
				if (({1'b0, pos_q} + 1'b1) >= {1'b0, aend_q}) begin
					sn_go  = 1'b1;
					sn_pos = aend_q;
				end
			end
			default: begin
			end
		endcase

		// Move on to the next attribute, or close the walk at the packet end.
		if (sn_go) begin
			if (sn_pos >= {1'b0, len_d}) begin
				if (sn_pos != {1'b0, len_d}) begin
					err_d = 1'b1;
				end
				phase_d = PH_TRAIL;
			end else begin
				phase_d = PH_ATTR;
				begin_d = sn_pos[15:0];
				shift_d = '0;
			end
		end

		pos_d = (pos_q == {POS_W{1'b1}}) ? pos_q : pos_q + 1'b1;

		err_v   = err_d | (phase_d != PH_TRAIL);
		r1      = '0;
		r1.kind = KIND_END;
		r1.ok   = ~(err_v & check_enable);
		r1.last = 1'b1;
	end

	assign res.v0 = step & emit;
	assign res.r0 = r0;
	assign res.v1 = step & eob;
	assign res.r1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			num_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			shift_q <= '0;
			begin_q <= '0;
			aend_q  <= '0;
			phase_q <= PH_HEADER;
			err_q   <= 1'b0;
		end else if (step) begin
			if (eob) begin
				pos_q   <= '0;
				num_q   <= '0;
				type_q  <= '0;
				len_q   <= '0;
				shift_q <= '0;
				begin_q <= '0;
				aend_q  <= '0;
				phase_q <= PH_HEADER;
				err_q   <= 1'b0;
			end else begin
				pos_q   <= pos_d;
				num_q   <= num_d;
				type_q  <= type_d;
				len_q   <= len_d;
				shift_q <= shift_d;
				begin_q <= begin_d;
				aend_q  <= aend_d;
				phase_q <= phase_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

// ===== src/tlvp_out_queue.sv =====
// Small result queue: takes up to two results a cycle, hands out one while the reader is ready.
module tlvp_out_queue
	import tlvp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t push,
	output result_t   head,
	output logic      head_valid,
	input  logic      head_ready,
	output q_status_t status
);

	result_t           entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	result_t           first;
	logic [1:0]        n_push;
	logic              pop;

	assign first      = push.v0 ? push.r0 : push.r1;
	assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
	assign head_valid = (cnt_q != '0);
	assign head       = entries_q[rd_q];
	assign pop        = head_valid & head_ready;

	assign status.room  = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign status.level = cnt_q;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			entries_q[wr_q] <= first;
		end
		if (n_push == 2'd2) begin
			entries_q[wr_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(n_push);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

endmodule
